>>> src/aidp_pkg.sv
// Shared types and codes for the positional list block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package aidp_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic [2:0] REG_CAPACITY = 3'd0;

    typedef struct packed {
        logic accept;
        logic shift_rd;
        logic shift_wr;
        logic write_new;
        logic read_pos;
        logic read_cap;
        logic count_dec;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] chk;
        logic       shift_more;
    } t_dp_stat;

endpackage

>>> src/aidp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module aidp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/aidp_dp.sv
// Datapath: entry store, entry count, shift index, checks and result registers.
// Depends on aidp_pkg and aidp_ram.
`timescale 1ns / 1ps

module aidp_dp #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aidp_pkg::t_dp_cmd i_cmd,
    output aidp_pkg::t_dp_stat o_stat,
    input  logic [6:0]        i_capacity,
    input  logic [1:0]        i_kind,
    input  logic [6:0]        i_position,
    input  logic [31:0]       i_value,
    output logic [1:0]        o_status,
    output logic [6:0]        o_entry_count,
    output logic [31:0]       o_read_value
);

    import aidp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > 7) ? CW : 7;

    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_j;
    logic [1:0]           r_kind;
    logic [1:0]           r_chk;
    logic [6:0]           r_pos;
    logic [31:0]          r_value;
    logic [31:0]          r_rd;
    logic [1:0]           r_out_status;
    logic [6:0]           r_out_count;
    logic [31:0]          r_out_read;

    logic [KW-1:0]        count_k;
    logic [KW-1:0]        cap_k;
    logic [KW-1:0]        depth_k;
    logic [KW-1:0]        cap_eff;
    logic [KW-1:0]        pos_k;
    logic [KW-1:0]        rpos_k;
    logic                 pos_bad_ins;
    logic                 pos_bad;
    logic [1:0]           chk;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word_in;
    logic [31:0]          read_ext;

    assign count_k = KW'(r_count);
    assign cap_k   = KW'(i_capacity);
    assign depth_k = KW'(DEPTH);
    assign cap_eff = (cap_k > depth_k) ? depth_k : cap_k;
    assign pos_k   = KW'(i_position);
    assign rpos_k  = KW'(r_pos);

    assign pos_bad_ins = (pos_k == '0) || (pos_k > count_k + KW'(1));
    assign pos_bad     = (pos_k == '0) || (pos_k > count_k);

    always_comb begin
        chk = ST_OK;
        case (i_kind)
            KIND_INSERT: begin
                if (count_k >= cap_eff) begin
                    chk = ST_OVERFLOW;
                end else if (pos_bad_ins) begin
                    chk = ST_RANGE;
                end
            end
            KIND_DELETE: begin
                if (count_k == '0) begin
                    chk = ST_UNDERFLOW;
                end else if (pos_bad) begin
                    chk = ST_RANGE;
                end
            end
            KIND_READ: begin
                if (pos_bad) begin
                    chk = ST_RANGE;
                end
            end
            default: chk = ST_OK;
        endcase
    end

    always_comb begin
        o_stat.kind = r_kind;
        o_stat.chk  = r_chk;
        case (r_kind)
            KIND_INSERT: o_stat.shift_more = (KW'(r_j) >= rpos_k);
            KIND_DELETE: o_stat.shift_more = (KW'(r_j) + KW'(1) < count_k);
            default:     o_stat.shift_more = 1'b0;
        endcase
    end

    // Word conversion between the 32-bit ports and the stored width
    generate
        if (WORD_BITS < 32) begin : g_narrow
            assign word_in  = r_value[WORD_BITS-1:0];
            assign read_ext = {{(32-WORD_BITS){ram_rdata[WORD_BITS-1]}}, ram_rdata};
        end else if (WORD_BITS == 32) begin : g_equal
            assign word_in  = r_value;
            assign read_ext = ram_rdata;
        end else begin : g_wide
            assign word_in  = {{(WORD_BITS-32){r_value[31]}}, r_value};
            assign read_ext = ram_rdata[31:0];
        end
    endgenerate

    always_comb begin
        if (i_cmd.read_pos) begin
            ram_raddr = AW'(rpos_k - KW'(1));
        end else if (r_kind == KIND_INSERT) begin
            ram_raddr = r_j - AW'(1);
        end else begin
            ram_raddr = r_j + AW'(1);
        end
        ram_we    = i_cmd.shift_wr | i_cmd.write_new;
        ram_waddr = i_cmd.write_new ? AW'(rpos_k - KW'(1)) : r_j;
        ram_wdata = i_cmd.write_new ? word_in : ram_rdata;
    end

    aidp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write_new) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_chk   <= chk;
            r_pos   <= i_position;
            r_value <= i_value;
            r_rd    <= '0;
            // insert walks down from the tail, delete walks up from the hole
            r_j     <= (i_kind == KIND_INSERT) ? AW'(r_count) : AW'(pos_k - KW'(1));
        end else begin
            if (i_cmd.shift_wr) begin
                r_j <= (r_kind == KIND_INSERT) ? r_j - AW'(1) : r_j + AW'(1);
            end
            if (i_cmd.read_cap) begin
                r_rd <= read_ext;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_chk;
            r_out_count  <= 7'(r_count);
            r_out_read   <= r_rd;
        end
    end

    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_read_value  = r_out_read;

endmodule

>>> src/aidp_ctrl.sv
// Controller state machine: sequences accept, shift steps, store, read capture and result beat.
// Depends on aidp_pkg.
`timescale 1ns / 1ps

module aidp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output aidp_pkg::t_dp_cmd  o_cmd,
    input  aidp_pkg::t_dp_stat i_stat
);

    import aidp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE_NEW,
        S_READ_CAP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.chk != ST_OK) begin
                    n_state = S_DONE;
                end else begin
                    case (i_stat.kind)
                        KIND_INSERT: begin
                            n_state = i_stat.shift_more ? S_SHIFT_RD : S_WRITE_NEW;
                        end
                        KIND_DELETE: begin
                            if (i_stat.shift_more) begin
                                n_state = S_SHIFT_RD;
                            end else begin
                                o_cmd.count_dec = 1'b1;
                                n_state         = S_DONE;
                            end
                        end
                        KIND_READ: begin
                            o_cmd.read_pos = 1'b1;
                            n_state        = S_READ_CAP;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT_RD: begin
                o_cmd.shift_rd = 1'b1;
                n_state        = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_DISPATCH;
            end
            S_WRITE_NEW: begin
                o_cmd.write_new = 1'b1;
                n_state         = S_DONE;
            end
            S_READ_CAP: begin
                o_cmd.read_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // load the result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/array_insert_delete_at_position_top.sv
// Ordered list of signed words with insert, delete and read at a 1-based
// position. One item is in work at a time; the store is a RAM with one write
// and one registered read port, and each entry moved by an insert or delete
// costs a read step, a write step and a loop check. After the result beat
// enters the output register the block returns to idle before it can take
// the next item. The next item is taken while the previous result still
// waits in that register. Capacity is set through the APB register at
// address 0 (reset 64, saturated to DEPTH).
// Depends on aidp_pkg, aidp_ctrl, aidp_dp and aidp_ram.
`timescale 1ns / 1ps

module array_insert_delete_at_position_top #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_count,
    output logic [31:0] o_read_value
);

    import aidp_pkg::*;

    logic [6:0] r_capacity;
    logic       cfg_hit;
    t_dp_cmd    cmd;
    t_dp_stat   stat;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr == REG_CAPACITY);
    assign prdata  = cfg_hit ? {25'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 7'd64;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_capacity <= pwdata[6:0];
        end
    end

    aidp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    aidp_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_capacity    (r_capacity),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_read_value  (o_read_value)
    );

endmodule
